### rtl/wegb_pkg.sv
// Package for the weighted entropy Gaussian bound block: widths, fixed-point
// constants and the mantissa log table used by the log units.
// No dependencies; wegb_ln and the top level import it.
`timescale 1ns / 1ps

package wegb_pkg;

  // Field widths
  localparam int WEIGHT_W         = 16;
  localparam int WEIGHT_FRAC_BITS = 15;
  localparam int SIGMA_W          = 16;
  localparam int SIGMA_FRAC_BITS  = 8;
  localparam int ENTROPY_W        = 24;

  // Log unit: input width, table size and result width (unsigned Q16)
  localparam int LN_IN_W          = 16;
  localparam int LN_MSB_W         = $clog2(LN_IN_W);
  localparam int LN_TABLE_ENTRIES = 64;
  localparam int LN_IDX_W         = $clog2(LN_TABLE_ENTRIES);
  localparam int LN_MANT_W        = 16;
  localparam int LN_W             = 20;

  // Datapath widths
  localparam int COEF_W = 23;
  localparam int PROD_W = WEIGHT_W + 1 + COEF_W;
  localparam int TERM_W = 25;
  localparam int ACC_W  = 40;

  // Q16 constants, rounded to nearest
  localparam int LN2_Q16     = 45426;
  localparam int LN_2PIE_Q16 = 185983;

  // Constant part of the per-weight coefficient:
  // ln(2*pi*e) - 2*SIGMA_FRAC_BITS*ln2 + WEIGHT_FRAC_BITS*ln2
  localparam int COEF_BASE = LN_2PIE_Q16 - 2 * SIGMA_FRAC_BITS * LN2_Q16
                             + WEIGHT_FRAC_BITS * LN2_Q16;

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd256;

  typedef logic [LN_TABLE_ENTRIES-1:0][LN_MANT_W-1:0] ln_tab_t;

  // Builds ln(1 + k/N) in Q16 with the series 2*atanh(k/(2N+k)) in Q32.
  // Evaluated once at elaboration to fill a constant table.
  function automatic ln_tab_t ln_tab_build();
    ln_tab_t     tab;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] sum;
    for (int k = 0; k < LN_TABLE_ENTRIES; k++) begin
      z   = (64'(k) << 32) / 64'(2 * LN_TABLE_ENTRIES + k);
      z2  = (z * z) >> 32;
      p   = z;
      sum = 64'd0;
      for (int i = 0; i < 24; i++) begin
        sum = sum + p / 64'(2 * i + 1);
        p   = (p * z2) >> 32;
      end
      sum    = sum << 1;
      tab[k] = LN_MANT_W'((sum + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam ln_tab_t LN_TAB = ln_tab_build();

endpackage

### rtl/wegb_in_if.sv
// Channel interfaces of the weighted entropy block: weight input and result output.
// Each carries valid, ready and the payload. No dependencies.
`timescale 1ns / 1ps

interface wegb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] particle_weight;
  logic        end_of_set;

  modport source (output valid, output particle_weight, output end_of_set, input ready);
  modport sink   (input valid, input particle_weight, input end_of_set, output ready);
endinterface

interface wegb_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] entropy_value;
  logic               sigma_invalid;
  logic               saturated;

  modport source (output valid, output entropy_value, output sigma_invalid,
                  output saturated, input ready);
  modport sink   (input valid, input entropy_value, input sigma_invalid,
                  input saturated, output ready);
endinterface

### rtl/wegb_ln.sv
// Natural log unit: ln(x) in unsigned Q16 for a nonzero 16-bit integer x.
// Uses the msb position times ln2 plus the mantissa table from wegb_pkg.
`timescale 1ns / 1ps

module wegb_ln (
  input  logic [wegb_pkg::LN_IN_W-1:0] x,
  output logic [wegb_pkg::LN_W-1:0]    ln_q16
);
  import wegb_pkg::*;

  logic [LN_MSB_W-1:0] msb;
  logic [LN_IN_W-1:0]  norm;
  logic [LN_IDX_W-1:0] idx;

  // Position of the leading one
  always_comb begin
    msb = '0;
    for (int i = 0; i < LN_IN_W; i++) begin
      if (x[i]) begin
        msb = LN_MSB_W'(i);
      end
    end
  end

  // Normalize so the leading one sits at the top; the bits below it index the table
  assign norm = x << (LN_MSB_W'(LN_IN_W - 1) - msb);
  assign idx  = norm[LN_IN_W-2 -: LN_IDX_W];

  assign ln_q16 = LN_W'(msb) * LN_W'(LN2_Q16) + LN_W'(LN_TAB[idx]);

endmodule

### rtl/weighted_entropy_gaussian_bound.sv
// Weighted entropy Gaussian bound, top level.
// Depends on wegb_pkg, the channel interfaces and wegb_ln.
`timescale 1ns / 1ps

// Usage:
// Weights stream in on in_chan, one per transfer, with end_of_set high on the
// last weight of a set. Each nonzero weight w adds w*(ln(2*pi*e*sigma^2) - ln w)
// to a 40-bit saturating accumulator. The transfer that carries end_of_set
// produces one result on out_chan (entropy in signed Q8.16, clipped, with
// sigma_invalid and saturated flags) and clears the accumulator; other
// transfers produce no result.
// The sigma register is written through cfg_we / cfg_wdata; the user must write
// it only while the block is idle, which the block does not enforce. A zero
// sigma gives a zero result with sigma_invalid set. Throughput is one weight per
// cycle while the input is not stalled. A set-ending weight passes the stage-1
// register, the log units and multiplier, the stage-2 register and the
// accumulator and clipping into the output register. When the receiver stalls,
// weights that do not end a set keep flowing into the accumulator; input stalls
// only once a set-ending weight reaches the accumulator stage while the previous
// result is still waiting. Reset (synchronous, active low) empties the pipeline,
// clears the accumulator and loads sigma with 1.0 (256 in Q8.8).
module weighted_entropy_gaussian_bound (
  input  logic                         clk,
  input  logic                         rst_n,
  wegb_in_if.sink                      in_chan,
  wegb_out_if.source                   out_chan,
  input  logic                         cfg_we,
  input  logic [wegb_pkg::SIGMA_W-1:0] cfg_wdata
);
  import wegb_pkg::*;

  localparam logic signed [COEF_W-1:0]    COEF_BASE_C = COEF_W'(COEF_BASE);
  localparam logic signed [ACC_W-1:0]     ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]     ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ENTROPY_W-1:0] OUT_MAX = {1'b0, {(ENTROPY_W-1){1'b1}}};
  localparam logic signed [ENTROPY_W-1:0] OUT_MIN = {1'b1, {(ENTROPY_W-1){1'b0}}};

  // Configuration
  logic [SIGMA_W-1:0] sigma_r;

  // Stage 1: registered input weight
  logic                s1_valid_r;
  logic [WEIGHT_W-1:0] s1_weight_r;
  logic                s1_last_r;

  // Stage 2: registered term
  logic                     s2_valid_r;
  logic                     s2_last_r;
  logic signed [TERM_W-1:0] s2_term_r;

  // Accumulator
  logic signed [ACC_W-1:0] acc_r;
  logic                    ovf_r;

  // Output register
  logic                        out_valid_r;
  logic signed [ENTROPY_W-1:0] out_entropy_r;
  logic                        out_inval_r;
  logic                        out_sat_r;

  // Flow control
  logic out_free;
  logic s2_adv;
  logic s2_take;
  logic s1_adv;
  logic in_fire;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s2_adv   = s2_valid_r && (!s2_last_r || out_free);
  assign s2_take  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_take;
  assign in_chan.ready = !s1_valid_r || s2_take;
  assign in_fire  = in_chan.valid && in_chan.ready;

  // Sigma register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RESET;
    end else if (cfg_we) begin
      sigma_r <= cfg_wdata;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_weight_r <= in_chan.particle_weight;
      s1_last_r   <= in_chan.end_of_set;
    end
  end

  // Log of the weight and of sigma
  logic [LN_W-1:0] ln_w;
  logic [LN_W-1:0] ln_s;

  wegb_ln u_ln_weight (
    .x      (s1_weight_r),
    .ln_q16 (ln_w)
  );

  wegb_ln u_ln_sigma (
    .x      (sigma_r),
    .ln_q16 (ln_s)
  );

  // Coefficient, product and floored term
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] term_nxt;
  logic                     contrib;

  assign contrib = (s1_weight_r != '0) && (sigma_r != '0);
  assign coef    = COEF_BASE_C + $signed(COEF_W'({ln_s, 1'b0})) - $signed(COEF_W'(ln_w));
  assign prod    = PROD_W'($signed({1'b0, s1_weight_r})) * PROD_W'(coef);
  assign term_nxt = contrib ? TERM_W'(prod >>> WEIGHT_FRAC_BITS) : '0;

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_take) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_term_r <= term_nxt;
      s2_last_r <= s1_last_r;
    end
  end

  // Saturating accumulate
  logic signed [ACC_W:0]       sum;
  logic signed [ACC_W-1:0]     acc_sat;
  logic                        ovf_sum;
  logic                        ovf_nxt;
  logic                        out_clip;
  logic signed [ENTROPY_W-1:0] res_nxt;
  logic                        sat_nxt;
  logic                        inval;

  assign sum     = $signed({acc_r[ACC_W-1], acc_r}) + (ACC_W+1)'(s2_term_r);
  assign ovf_sum = sum[ACC_W] != sum[ACC_W-1];
  assign acc_sat = ovf_sum ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
  assign ovf_nxt = ovf_r || ovf_sum;
  assign inval   = sigma_r == '0;

  // Output clipping to the result width
  assign out_clip = (acc_sat[ACC_W-1:ENTROPY_W-1] != '0)
                    && (acc_sat[ACC_W-1:ENTROPY_W-1] != '1);

  always_comb begin
    if (inval) begin
      res_nxt = '0;
      sat_nxt = 1'b0;
    end else if (out_clip) begin
      res_nxt = acc_sat[ACC_W-1] ? OUT_MIN : OUT_MAX;
      sat_nxt = 1'b1;
    end else begin
      res_nxt = acc_sat[ENTROPY_W-1:0];
      sat_nxt = ovf_nxt;
    end
  end

  // Accumulator update; a set end clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (s2_adv) begin
      if (s2_last_r) begin
        acc_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        acc_r <= acc_sat;
        ovf_r <= ovf_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_adv && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_last_r) begin
      out_entropy_r <= res_nxt;
      out_inval_r   <= inval;
      out_sat_r     <= sat_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.entropy_value = out_entropy_r;
  assign out_chan.sigma_invalid = out_inval_r;
  assign out_chan.saturated     = out_sat_r;

endmodule
